FILE: hdl/wobsd_pkg.sv
// wobsd_pkg: shared types, constants and codes of the wired-OR bus settle dispatcher.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps
package wobsd_pkg;

	// Fixed field widths
	localparam int LINE_BITS  = 18;
	localparam int BUSY_BIT   = 12;
	localparam int DEV_W      = 3;
	localparam int STEP_W     = 16;
	localparam int TIME_W     = 20;
	localparam int STAGE_W    = 4;

	// Threshold register file
	localparam int NUM_THRESH = 8;
	localparam int THR_W      = 16;
	localparam int THR_IDX_W  = 3;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// Parameter defaults
	localparam int DEVICES_DEF = 8;
	localparam int STAGES_DEF  = 8;

	// Command codes
	localparam logic CMD_DRIVE = 1'b0;
	localparam logic CMD_TIME  = 1'b1;

	typedef logic [NUM_THRESH-1:0][THR_W-1:0] thr_vec_t;

	typedef struct packed {
		logic                 cmd;
		logic [DEV_W-1:0]     device_id;
		logic [LINE_BITS-1:0] drive_value;
		logic [STEP_W-1:0]    time_step;
	} req_t;

	typedef struct packed {
		logic [LINE_BITS-1:0] bus_lines;
		logic                 notify;
		logic [TIME_W-1:0]    elapsed;
		logic                 busy_changed;
		logic                 busy_level;
		logic [STAGE_W-1:0]   stage;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic accept_drive;
		logic accept_time;
		logic step_en;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic step_more;
	} dp_status_t;

endpackage

FILE: hdl/wobsd_regs.sv
// wobsd_regs: APB-style threshold register file, eight 16-bit registers at 4*i.
// Depends on wobsd_pkg.
`timescale 1ns / 1ps
module wobsd_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wobsd_pkg::ADDR_W-1:0]  paddr,
	input  logic [wobsd_pkg::DATA_W-1:0]  pwdata,
	output logic [wobsd_pkg::DATA_W-1:0]  prdata,
	output logic                          pready,
	output wobsd_pkg::thr_vec_t           thr
);

	wobsd_pkg::thr_vec_t                  thr_q;
	logic [wobsd_pkg::THR_IDX_W-1:0]      idx;

	assign idx    = paddr[wobsd_pkg::ADDR_W-1:2];
	assign pready = 1'b1;
	assign prdata = {{(wobsd_pkg::DATA_W-wobsd_pkg::THR_W){1'b0}}, thr_q[idx]};
	assign thr    = thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < wobsd_pkg::NUM_THRESH; i++) begin
				thr_q[i] <= wobsd_pkg::THR_W'(i + 1);
			end
		end else if (psel && penable && pwrite) begin
			thr_q[idx] <= pwdata[wobsd_pkg::THR_W-1:0];
		end
	end

endmodule

FILE: hdl/wobsd_ctrl.sv
// wobsd_ctrl: sequencer for one request at a time and the result valid flag.
// Depends on wobsd_pkg.
`timescale 1ns / 1ps
module wobsd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_cmd,
	output logic                  req_ready,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output wobsd_pkg::dp_cmd_t    cmd,
	input  wobsd_pkg::dp_status_t status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_STEP = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       take;

	assign req_ready = (state_q == S_IDLE);
	assign take      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d          = state_q;
		cmd.accept_drive = 1'b0;
		cmd.accept_time  = 1'b0;
		cmd.step_en      = 1'b0;
		cmd.load_out     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					if (req_cmd == wobsd_pkg::CMD_TIME) begin
						cmd.accept_time = 1'b1;
						state_d         = S_STEP;
					end else begin
						cmd.accept_drive = 1'b1;
						state_d          = S_DONE;
					end
				end
			end
			S_STEP: begin
				// one threshold compare per cycle
				if (status.step_more) begin
					cmd.step_en = 1'b1;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> rsp_valid_q)
		else $error("result not presented after load");
	a_step_ends_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP && !status.step_more) |=> state_q == S_DONE)
		else $error("stage walk did not finish");
	a_wait_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && rsp_valid_q && !rsp_ready) |=> state_q == S_DONE)
		else $error("result overwritten while stalled");

endmodule

FILE: hdl/wobsd_dp.sv
// wobsd_dp: drive registers, bus OR, settle timer, stage walker and result register.
// Depends on wobsd_pkg.
`timescale 1ns / 1ps
module wobsd_dp #(
	parameter int DEVICES = wobsd_pkg::DEVICES_DEF,
	parameter int STAGES  = wobsd_pkg::STAGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  wobsd_pkg::req_t       req,
	input  wobsd_pkg::thr_vec_t   thr,
	input  wobsd_pkg::dp_cmd_t    cmd,
	output wobsd_pkg::dp_status_t status,
	output wobsd_pkg::rsp_t       rsp
);

	localparam int LB = wobsd_pkg::LINE_BITS;
	localparam int TW = wobsd_pkg::TIME_W;
	localparam int SW = wobsd_pkg::STAGE_W;

	logic [DEVICES-1:0][LB-1:0] drive_q;
	logic [LB-1:0]              bus_q;
	logic [TW-1:0]              time_q;
	logic [SW-1:0]              stage_q;
	logic [SW-1:0]              old_stage_q;
	logic                       is_time_q;
	logic                       busy_chg_q;
	wobsd_pkg::rsp_t            rsp_q;

	logic                       dev_ok;
	logic [LB-1:0]              new_or;
	logic [TW:0]                sum;
	logic                       stage_live;

	assign dev_ok     = 32'(req.device_id) < 32'(DEVICES);
	assign stage_live = 32'(stage_q) < 32'(STAGES);
	assign sum        = {1'b0, time_q} + (TW + 1)'(req.time_step);

	// OR with the incoming value substituted for its device
	always_comb begin
		new_or = '0;
		for (int i = 0; i < DEVICES; i++) begin
			if (dev_ok && i == int'(req.device_id)) begin
				new_or = new_or | req.drive_value;
			end else begin
				new_or = new_or | drive_q[i];
			end
		end
	end

	assign status.step_more = stage_live &&
		({4'b0, thr[stage_q[wobsd_pkg::THR_IDX_W-1:0]]} <= time_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_q     <= '0;
			bus_q       <= '0;
			time_q      <= '0;
			stage_q     <= SW'(STAGES);
			old_stage_q <= SW'(STAGES);
			is_time_q   <= 1'b0;
			busy_chg_q  <= 1'b0;
		end else begin
			if (cmd.accept_drive) begin
				is_time_q  <= 1'b0;
				busy_chg_q <= 1'b0;
				if (dev_ok) begin
					for (int i = 0; i < DEVICES; i++) begin
						if (i == int'(req.device_id)) begin
							drive_q[i] <= req.drive_value;
						end
					end
					bus_q <= new_or;
					if (new_or != bus_q) begin
						busy_chg_q <= new_or[wobsd_pkg::BUSY_BIT] ^
							bus_q[wobsd_pkg::BUSY_BIT];
						stage_q    <= '0;
						time_q     <= '0;
					end
				end
			end
			if (cmd.accept_time) begin
				is_time_q   <= 1'b1;
				busy_chg_q  <= 1'b0;
				old_stage_q <= stage_q;
				if (stage_live) begin
					time_q <= sum[TW] ? '1 : sum[TW-1:0];
				end
			end
			if (cmd.step_en) begin
				stage_q <= stage_q + SW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			rsp_q.bus_lines    <= bus_q;
			rsp_q.notify       <= is_time_q && (stage_q != old_stage_q);
			rsp_q.elapsed      <= time_q;
			rsp_q.busy_changed <= busy_chg_q;
			rsp_q.busy_level   <= bus_q[wobsd_pkg::BUSY_BIT];
			rsp_q.stage        <= stage_q;
		end
	end

	assign rsp = rsp_q;

	a_stage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(stage_q) <= 32'(STAGES))
		else $error("stage beyond idle");
	a_time_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept_time |=> time_q >= $past(time_q))
		else $error("settle timer went backwards");
	a_step_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_en |=> stage_q == $past(stage_q) + SW'(1))
		else $error("stage walk skipped");

endmodule

FILE: hdl/wired_or_bus_settle_dispatcher.sv
// wired_or_bus_settle_dispatcher: top level joining registers, controller and datapath.
// Depends on wobsd_pkg, wobsd_regs, wobsd_ctrl, wobsd_dp.
`timescale 1ns / 1ps
// Usage
//  - Request channel (req_valid/req_ready/req): cmd DRIVE stores one device's line
//    vector and recomputes the wired-OR bus; cmd TIME adds elapsed half-cycles to the
//    settle timer (saturating at 20 bits) and walks the settle stage past met thresholds.
//  - Result channel (rsp_valid/rsp_ready/rsp): exactly one result per request, in order.
//  - APB port: eight 16-bit thresholds at byte address 4*i, written while idle.
// Sequence
//  - One request in flight. A drive request goes from idle to the done state, which loads
//    the result register once the result channel is free, and then back to idle.
//  - A time request goes from idle through the stage walk, which compares one threshold
//    per cycle and steps past 0..8 met thresholds, then to done and back to idle.
//  - Next request is taken the cycle after the result is loaded, even if it is still
//    waiting downstream: the result register decouples the two sides.
// Reset (arst_n low): drives, bus and timer zero, stage idle, thresholds 1..8, no result.
// Stall: a held result keeps the controller in its done state; nothing is lost.
module wired_or_bus_settle_dispatcher #(
	parameter int DEVICES = wobsd_pkg::DEVICES_DEF,
	parameter int STAGES  = wobsd_pkg::STAGES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          req_valid,
	output logic                          req_ready,
	input  wobsd_pkg::req_t               req,
	// result channel
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output wobsd_pkg::rsp_t               rsp,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [wobsd_pkg::ADDR_W-1:0]  paddr,
	input  logic [wobsd_pkg::DATA_W-1:0]  pwdata,
	output logic [wobsd_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);

	wobsd_pkg::thr_vec_t   thr;
	wobsd_pkg::dp_cmd_t    dp_cmd;
	wobsd_pkg::dp_status_t dp_status;

	// threshold registers
	wobsd_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.thr     (thr)
	);

	// sequencer: idle -> (stage walk) -> done
	wobsd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (dp_cmd),
		.status    (dp_status)
	);

	// bus state, settle timer and result register
	wobsd_dp #(
		.DEVICES (DEVICES),
		.STAGES  (STAGES)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.thr    (thr),
		.cmd    (dp_cmd),
		.status (dp_status),
		.rsp    (rsp)
	);

endmodule

FILE: sim/testbench.sv
// testbench: self-checking bench for wired_or_bus_settle_dispatcher: a directed table, then
// random phases over several threshold settings and idling patterns, all checked in order.
// Depends on wobsd_pkg and the RTL under hdl/.
`timescale 1ns / 1ps
module testbench;

	// Threshold register indexes, in address order (byte address 4*i)
	typedef enum logic [wobsd_pkg::THR_IDX_W-1:0] {
		THR_CABLE_SKEW, THR_DESKEW, THR_BUS_FREE, THR_BUS_SETTLE,
		THR_BUS_CLEAR, THR_BUS_SET, THR_ARBITRATION, THR_RESET_HOLD
	} thr_index_e;

	typedef enum logic {ROW_REQUEST, ROW_REG_WRITE} row_kind_e;

	// One line of the directed table: a request (with its result typed in when it is
	// obvious, else left to the predictor) or a threshold write done while idle
	typedef struct {
		row_kind_e                       kind;
		wobsd_pkg::req_t                 request;
		bit                              known;
		wobsd_pkg::rsp_t                 result;
		thr_index_e                      reg_index;
		logic [wobsd_pkg::THR_W-1:0]     reg_value;
	} dir_row_t;

	localparam logic [wobsd_pkg::TIME_W-1:0] TIME_SAT = '1;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	wobsd_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	wobsd_pkg::rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [wobsd_pkg::ADDR_W-1:0] paddr;
	logic [wobsd_pkg::DATA_W-1:0] pwdata;
	logic [wobsd_pkg::DATA_W-1:0] prdata;
	logic pready;

	// Predictor state: the bench's own copy of drives, bus, timer, stage and thresholds
	logic [wobsd_pkg::LINE_BITS-1:0] line_drive [wobsd_pkg::DEVICES_DEF];
	logic [wobsd_pkg::LINE_BITS-1:0] bus_now;
	logic [wobsd_pkg::TIME_W-1:0]    elapsed_now;
	logic [wobsd_pkg::STAGE_W-1:0]   stage_now;
	logic [wobsd_pkg::THR_W-1:0]     thr_now [wobsd_pkg::NUM_THRESH];

	wobsd_pkg::rsp_t results_due [$];
	dir_row_t        dir_rows [$];
	int              mismatches = 0;
	int              gap_pct = 0;
	int              stall_pct = 0;

	wired_or_bus_settle_dispatcher uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	// Works out the result of one accepted request and moves the model state on.
	// Drive: store, re-OR, and on any bus change clear timer and stage.
	// Time: only below idle; saturating add, then walk past every met threshold in
	// order, stopping at the first one not met (thresholds need not be ascending).
	function automatic wobsd_pkg::rsp_t settle_predict(input wobsd_pkg::req_t r);
		wobsd_pkg::rsp_t o;
		logic [wobsd_pkg::LINE_BITS-1:0] prior;
		logic [wobsd_pkg::LINE_BITS-1:0] wired;
		logic [wobsd_pkg::TIME_W:0]      sum;
		logic [wobsd_pkg::STAGE_W-1:0]   from;
		o = '0;
		if (r.cmd == wobsd_pkg::CMD_DRIVE) begin
			if (int'(r.device_id) < wobsd_pkg::DEVICES_DEF) begin
				line_drive[r.device_id] = r.drive_value;
				wired = '0;
				for (int i = 0; i < wobsd_pkg::DEVICES_DEF; i++) wired |= line_drive[i];
				prior = bus_now;
				bus_now = wired;
				if (bus_now != prior) begin
					o.busy_changed = bus_now[wobsd_pkg::BUSY_BIT] ^
						prior[wobsd_pkg::BUSY_BIT];
					stage_now = '0;
					elapsed_now = '0;
				end
			end
		end else if (stage_now < wobsd_pkg::STAGES_DEF) begin
			from = stage_now;
			sum = elapsed_now + r.time_step;
			elapsed_now = (sum > TIME_SAT) ? TIME_SAT : sum[wobsd_pkg::TIME_W-1:0];
			while (stage_now < wobsd_pkg::STAGES_DEF && elapsed_now >= thr_now[stage_now])
				stage_now++;
			o.notify = (stage_now != from);
		end
		o.bus_lines  = bus_now;
		o.elapsed    = elapsed_now;
		o.busy_level = bus_now[wobsd_pkg::BUSY_BIT];
		o.stage      = stage_now;
		return o;
	endfunction

	function automatic wobsd_pkg::req_t mk_req(input logic c,
			input logic [wobsd_pkg::DEV_W-1:0] dev,
			input logic [wobsd_pkg::LINE_BITS-1:0] val,
			input logic [wobsd_pkg::STEP_W-1:0] step);
		wobsd_pkg::req_t r;
		r.cmd = c;
		r.device_id = dev;
		r.drive_value = val;
		r.time_step = step;
		return r;
	endfunction

	function automatic wobsd_pkg::rsp_t mk_rsp(input logic [wobsd_pkg::LINE_BITS-1:0] bus,
			input logic nt, input logic [wobsd_pkg::TIME_W-1:0] el, input logic bc,
			input logic bl, input logic [wobsd_pkg::STAGE_W-1:0] st);
		wobsd_pkg::rsp_t o;
		o.bus_lines = bus;
		o.notify = nt;
		o.elapsed = el;
		o.busy_changed = bc;
		o.busy_level = bl;
		o.stage = st;
		return o;
	endfunction

	task automatic add_row(input wobsd_pkg::req_t r);
		dir_row_t row;
		row.kind = ROW_REQUEST;
		row.request = r;
		row.known = 1'b0;
		row.result = '0;
		row.reg_index = THR_CABLE_SKEW;
		row.reg_value = '0;
		dir_rows.insert(dir_rows.size(), row);
	endtask

	task automatic add_known(input wobsd_pkg::req_t r, input wobsd_pkg::rsp_t e);
		add_row(r);
		dir_rows[$].known = 1'b1;
		dir_rows[$].result = e;
	endtask

	task automatic add_reg(input thr_index_e idx, input logic [wobsd_pkg::THR_W-1:0] v);
		add_row('0);
		dir_rows[$].kind = ROW_REG_WRITE;
		dir_rows[$].reg_index = idx;
		dir_rows[$].reg_value = v;
	endtask

	// APB write: setup cycle, access cycle, then a quiet cycle so that back-to-back
	// writes never raise and drop psel in the same step
	task automatic reg_write(input thr_index_e idx, input logic [wobsd_pkg::THR_W-1:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(wobsd_pkg::DATA_W-wobsd_pkg::THR_W){1'b0}}, v};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		thr_now[idx] = v;
		@(posedge clk);
	endtask

	// Drops valid and waits until every outstanding result has been taken
	task automatic drain_results();
		req_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// Offers one request after a random gap; returns at the edge that accepted it,
	// valid still high, so the next request can follow without a bubble.
	// Readiness is sampled at the falling edge, clear of the rising-edge updates.
	task automatic issue_request(input wobsd_pkg::req_t r, input bit known,
			input wobsd_pkg::rsp_t want);
		wobsd_pkg::rsp_t predicted;
		bit taken;
		while ($urandom_range(0, 99) < gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do begin
			@(negedge clk);
			taken = req_ready;
			@(posedge clk);
		end while (!taken);
		predicted = settle_predict(r);
		results_due.insert(results_due.size(), known ? want : predicted);
	endtask

	// Receiver: ready drawn afresh every cycle from the current stall rate
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Result checker: a result is taken at the next rising edge when valid and ready
	// are both high at the falling edge; compare it there with the oldest expectation
	always @(negedge clk) begin : result_check
		wobsd_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (results_due.size() == 0) begin
				$error("result with no request outstanding: %p", rsp);
				mismatches++;
			end else begin
				want = results_due.pop_front();
				if (rsp.bus_lines !== want.bus_lines) begin
					$error("bus_lines: expected %h, got %h", want.bus_lines, rsp.bus_lines);
					mismatches++;
				end
				if (rsp.notify !== want.notify) begin
					$error("notify: expected %b, got %b", want.notify, rsp.notify);
					mismatches++;
				end
				if (rsp.elapsed !== want.elapsed) begin
					$error("elapsed: expected %0d, got %0d", want.elapsed, rsp.elapsed);
					mismatches++;
				end
				if (rsp.busy_changed !== want.busy_changed) begin
					$error("busy_changed: expected %b, got %b", want.busy_changed,
						rsp.busy_changed);
					mismatches++;
				end
				if (rsp.busy_level !== want.busy_level) begin
					$error("busy_level: expected %b, got %b", want.busy_level,
						rsp.busy_level);
					mismatches++;
				end
				if (rsp.stage !== want.stage) begin
					$error("stage: expected %0d, got %0d", want.stage, rsp.stage);
					mismatches++;
				end
			end
		end
	end

	initial begin
		logic [wobsd_pkg::THR_W-1:0] thr_plan [wobsd_pkg::NUM_THRESH];
		int unsigned acc;
		int unsigned top;
		int unsigned step_cap;
		int unsigned pick;
		wobsd_pkg::req_t r;

		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		for (int i = 0; i < wobsd_pkg::DEVICES_DEF; i++) line_drive[i] = '0;
		for (int i = 0; i < wobsd_pkg::NUM_THRESH; i++)
			thr_now[i] = wobsd_pkg::THR_W'(i + 1);
		bus_now = '0;
		elapsed_now = '0;
		stage_now = wobsd_pkg::STAGES_DEF;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, reset thresholds 1..8. Unused fields carry noise in places.
		// Time while idle: nothing moves
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd7, 18'h3FFFF, 16'hFFFF),
			mk_rsp('0, 0, 0, 0, 0, 8));
		// Drive that leaves the bus as it was
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd0, 18'h0, 16'h0),
			mk_rsp('0, 0, 0, 0, 0, 8));
		// All lines high from the last device: busy toggles, stage restarts
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd7, 18'h3FFFF, 16'h0),
			mk_rsp(18'h3FFFF, 0, 0, 1, 1, 0));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'h0),
			mk_rsp(18'h3FFFF, 0, 0, 0, 1, 0));
		// Largest step passes every threshold at once
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'hFFFF),
			mk_rsp(18'h3FFFF, 1, 20'hFFFF, 0, 1, 8));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd5, 18'h2AAAA, 16'hFFFF),
			mk_rsp(18'h3FFFF, 0, 20'hFFFF, 0, 1, 8));
		// Hidden under the other device's lines: bus unchanged, timer kept
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd3, 18'h00FFF, 16'h0),
			mk_rsp(18'h3FFFF, 0, 20'hFFFF, 0, 1, 8));
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd7, 18'h0, 16'h0),
			mk_rsp(18'h00FFF, 0, 0, 1, 0, 0));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd1),
			mk_rsp(18'h00FFF, 1, 1, 0, 0, 1));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd1),
			mk_rsp(18'h00FFF, 1, 2, 0, 0, 2));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd0),
			mk_rsp(18'h00FFF, 0, 2, 0, 0, 2));
		// Bus change without a busy toggle
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd3, 18'h00FFE, 16'h0),
			mk_rsp(18'h00FFE, 0, 0, 0, 0, 0));
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd5, 18'h01000, 16'h0),
			mk_rsp(18'h01FFE, 0, 0, 1, 1, 0));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd5),
			mk_rsp(18'h01FFE, 1, 5, 0, 1, 5));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd3),
			mk_rsp(18'h01FFE, 1, 8, 0, 1, 8));
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd5, 18'h01000, 16'h0),
			mk_rsp(18'h01FFE, 0, 8, 0, 1, 8));
		// Out-of-order thresholds 3, 0, 2, 10, 5, 6, 7, 8: the walk runs through
		// whatever is met and halts at the first miss
		add_reg(THR_CABLE_SKEW, 16'd3);
		add_reg(THR_DESKEW, 16'd0);
		add_reg(THR_BUS_FREE, 16'd2);
		add_reg(THR_BUS_SETTLE, 16'd10);
		add_known(mk_req(wobsd_pkg::CMD_DRIVE, 3'd0, 18'h20000, 16'h0),
			mk_rsp(18'h21FFE, 0, 0, 0, 1, 0));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd2),
			mk_rsp(18'h21FFE, 0, 2, 0, 1, 0));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd1),
			mk_rsp(18'h21FFE, 1, 3, 0, 1, 3));
		add_known(mk_req(wobsd_pkg::CMD_TIME, 3'd0, 18'h0, 16'd7),
			mk_rsp(18'h21FFE, 1, 10, 0, 1, 8));
		// Remaining devices and alternating patterns, left to the predictor
		add_row(mk_req(wobsd_pkg::CMD_DRIVE, 3'd1, 18'h2AAAA, 16'h0));
		add_row(mk_req(wobsd_pkg::CMD_DRIVE, 3'd2, 18'h15555, 16'h0));
		add_row(mk_req(wobsd_pkg::CMD_DRIVE, 3'd4, 18'h3FFFF, 16'hFFFF));
		add_row(mk_req(wobsd_pkg::CMD_DRIVE, 3'd6, 18'h00001, 16'h0));
		add_row(mk_req(wobsd_pkg::CMD_TIME, 3'd7, 18'h3FFFF, 16'h8000));

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG_WRITE) begin
				drain_results();
				reg_write(dir_rows[i].reg_index, dir_rows[i].reg_value);
			end else begin
				issue_request(dir_rows[i].request, dir_rows[i].known, dir_rows[i].result);
			end
		end

		// Random phases: each one reprograms all eight thresholds while idle and
		// runs under one of four idling patterns
		for (int phase = 0; phase < 8; phase++) begin
			drain_results();
			case (phase % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 83; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 83; end
				default: begin gap_pct = 34; stall_pct = 34; end
			endcase
			acc = 0;
			for (int k = 0; k < wobsd_pkg::NUM_THRESH; k++) begin
				case (phase)
					0: thr_plan[k] = '0;
					1: thr_plan[k] = '1;
					2: begin
						acc += $urandom_range(0, 12);
						thr_plan[k] = wobsd_pkg::THR_W'(acc);
					end
					3: thr_plan[k] = wobsd_pkg::THR_W'($urandom_range(0, 40));
					4: thr_plan[k] = wobsd_pkg::THR_W'(k * 8192 + $urandom_range(0, 8191));
					5: thr_plan[k] = wobsd_pkg::THR_W'($urandom);
					6: begin
						pick = $urandom_range(0, 2);
						thr_plan[k] = (pick == 0) ? '0 : (pick == 1) ? '1 :
							wobsd_pkg::THR_W'($urandom_range(0, 64));
					end
					default: thr_plan[k] = wobsd_pkg::THR_W'(k + 1);
				endcase
				reg_write(thr_index_e'(k), thr_plan[k]);
			end
			// Time steps scaled so that the stage climbs over several requests
			top = 0;
			for (int k = 0; k < wobsd_pkg::NUM_THRESH; k++)
				if (thr_plan[k] > top) top = thr_plan[k];
			step_cap = top / 5 + 1;

			for (int n = 0; n < 64; n++) begin
				r.cmd = ($urandom_range(0, 99) < 55) ? wobsd_pkg::CMD_TIME :
					wobsd_pkg::CMD_DRIVE;
				r.device_id = wobsd_pkg::DEV_W'($urandom);
				r.drive_value = wobsd_pkg::LINE_BITS'($urandom);
				r.time_step = wobsd_pkg::STEP_W'($urandom);
				if (r.cmd == wobsd_pkg::CMD_DRIVE) begin
					// Bias towards values that actually move the bus, since the OR of
					// eight random vectors soon sticks at all ones
					pick = $urandom_range(0, 99);
					if (pick < 30)
						r.drive_value = '0;
					else if (pick < 50)
						r.drive_value = line_drive[r.device_id] ^
							(wobsd_pkg::LINE_BITS'(1) <<
							$urandom_range(0, wobsd_pkg::LINE_BITS - 1));
					else if (pick < 65)
						r.drive_value = line_drive[r.device_id] ^
							(wobsd_pkg::LINE_BITS'(1) << wobsd_pkg::BUSY_BIT);
					else if (pick < 75)
						r.drive_value = line_drive[r.device_id];
					else if (pick < 80)
						r.drive_value = '1;
				end else if ($urandom_range(0, 7) != 0) begin
					r.time_step = wobsd_pkg::STEP_W'($urandom_range(0, step_cap));
				end
				issue_request(r, 1'b0, '0);
			end
		end

		drain_results();
		// Anything arriving late is caught
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
